FILE: rtl/core/dcrpd_pkg.sv
// ----------------------------------------------------------------------------
// dcrpd_pkg
// Shared widths, operation codes, register indexes and the pipeline sideband
// type of the two-channel ramped pwm dimmer.
// ----------------------------------------------------------------------------
package dcrpd_pkg;

  localparam int unsigned OP_W        = 3;
  localparam int unsigned TIME_W      = 32;
  localparam int unsigned LEVEL_IN_W  = 16;
  localparam int unsigned LEVEL_OUT_W = 10;
  localparam int unsigned CMP_W       = 16;
  localparam int unsigned INTERVAL_W  = 16;
  localparam int unsigned STEP_W      = 10;
  localparam int unsigned PERIOD_W    = 17;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 17;

  // one product stage, then one reciprocal multiply stage
  localparam int unsigned SCALE_STAGES = 2;

  localparam logic [OP_W-1:0] OP_POLL      = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_WARM  = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_COOL  = 3'd2;
  localparam logic [OP_W-1:0] OP_SET_BOTH  = 3'd3;
  localparam logic [OP_W-1:0] OP_OFF       = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_STEP_INTERVAL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_SIZE     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PERIOD        = 2'd2;

  localparam logic [INTERVAL_W-1:0] RST_STEP_INTERVAL = 16'd10;
  localparam logic [STEP_W-1:0]     RST_STEP_SIZE     = 10'd10;
  localparam logic [PERIOD_W-1:0]   RST_PERIOD        = 17'd1000;

  typedef struct packed {
    logic [LEVEL_OUT_W-1:0] level_w;
    logic [LEVEL_OUT_W-1:0] level_c;
    logic [LEVEL_OUT_W-1:0] target_w;
    logic [LEVEL_OUT_W-1:0] target_c;
    logic                   updated;
    logic                   recompute;
    logic                   zero;
  } sb_t;

endpackage

FILE: rtl/core/dcrpd_cmd_if.sv
// ----------------------------------------------------------------------------
// dcrpd_cmd_if
// Command channel: operation, time stamp and requested levels.
// ----------------------------------------------------------------------------
interface dcrpd_cmd_if;
  logic                               valid;
  logic                               ready;
  logic [dcrpd_pkg::OP_W-1:0]         operation;
  logic [dcrpd_pkg::TIME_W-1:0]       now_ms;
  logic [dcrpd_pkg::LEVEL_IN_W-1:0]   warm_level_in;
  logic [dcrpd_pkg::LEVEL_IN_W-1:0]   cool_level_in;

  modport source (output valid, output operation, output now_ms,
                  output warm_level_in, output cool_level_in, input ready);
  modport sink   (input valid, input operation, input now_ms,
                  input warm_level_in, input cool_level_in, output ready);
endinterface

FILE: rtl/core/dcrpd_rsp_if.sv
// ----------------------------------------------------------------------------
// dcrpd_rsp_if
// Result channel: compare counts, current levels and targets.
// ----------------------------------------------------------------------------
interface dcrpd_rsp_if;
  logic                                valid;
  logic                                ready;
  logic [dcrpd_pkg::CMP_W-1:0]         warm_compare;
  logic [dcrpd_pkg::CMP_W-1:0]         cool_compare;
  logic [dcrpd_pkg::LEVEL_OUT_W-1:0]   warm_level_now;
  logic [dcrpd_pkg::LEVEL_OUT_W-1:0]   cool_level_now;
  logic [dcrpd_pkg::LEVEL_OUT_W-1:0]   warm_target_now;
  logic [dcrpd_pkg::LEVEL_OUT_W-1:0]   cool_target_now;
  logic                                compare_updated;

  modport source (output valid, output warm_compare, output cool_compare,
                  output warm_level_now, output cool_level_now,
                  output warm_target_now, output cool_target_now,
                  output compare_updated, input ready);
  modport sink   (input valid, input warm_compare, input cool_compare,
                  input warm_level_now, input cool_level_now,
                  input warm_target_now, input cool_target_now,
                  input compare_updated, output ready);
endinterface

FILE: rtl/core/dcrpd_cfg_if.sv
// ----------------------------------------------------------------------------
// dcrpd_cfg_if
// Register write channel: register index and write data.
// ----------------------------------------------------------------------------
interface dcrpd_cfg_if;
  logic                               valid;
  logic                               ready;
  logic [dcrpd_pkg::CFG_IDX_W-1:0]    index;
  logic [dcrpd_pkg::CFG_DATA_W-1:0]   data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: rtl/core/dual_channel_ramped_pwm_dimmer.sv
// ----------------------------------------------------------------------------
// dual_channel_ramped_pwm_dimmer
// Two-channel warm/cool led dimmer with slew-limited ramping and pwm compare
// computation.
//
//   channel  dir   handshake      carries
//   cfg      in    valid/ready    register index, write data
//   cmd      in    valid/ready    operation, now_ms, warm/cool level requests
//   rsp      out   valid/ready    compares, levels, targets, compare_updated
//
// One command per cycle sustained while rsp is ready; a result passes the
// input register, one stage while the levels settle, the product and
// reciprocal stages of the scale unit, then the output register.
// Ramp state is written as each command leaves s0, so back-to-back commands see it.
// Synchronous reset clears state, compares and all valid flags; cfg is
// always ready. A stalled rsp holds the pipeline and bubbles are squeezed
// out, so cmd keeps taking items until every stage is full.
// ----------------------------------------------------------------------------
module dual_channel_ramped_pwm_dimmer #(
  parameter int unsigned MAX_LEVEL = 1000
) (
  input  logic               clk,
  input  logic               rst,
  dcrpd_cfg_if.sink          cfg,
  dcrpd_cmd_if.sink          cmd,
  dcrpd_rsp_if.source        rsp
);
  import dcrpd_pkg::*;

  localparam int unsigned LW = $clog2(MAX_LEVEL + 1);
  localparam int unsigned NS = SCALE_STAGES + 1;

  // registers
  logic [INTERVAL_W-1:0] step_interval;
  logic [STEP_W-1:0]     step_size;
  logic [PERIOD_W-1:0]   period;

  // ramp state
  logic [LW-1:0]     warm_target, cool_target, warm_level, cool_level;
  logic [TIME_W-1:0] last_step_time;
  logic [LW-1:0]     warm_target_next, cool_target_next;
  logic [LW-1:0]     warm_level_next, cool_level_next;
  logic [TIME_W-1:0] last_step_time_next;
  logic              recompute, zero;

  // input register
  logic                  s0_valid;
  logic [OP_W-1:0]       s0_op;
  logic [TIME_W-1:0]     s0_now;
  logic [LEVEL_IN_W-1:0] s0_wl, s0_cl;

  // pipeline control
  logic [NS-1:0] v, v_next, ld, free, leave;
  logic          ld_out;
  sb_t           sb [NS];
  sb_t           sb_new;

  logic [LW-1:0]     ramp_w, ramp_c;
  logic              moved_w, moved_c;
  logic [TIME_W-1:0] elapsed;
  logic              step_due;
  logic [CMP_W-1:0]  cmp_w, cmp_c;

  function automatic logic [LW-1:0] clamp_level(input logic [LEVEL_IN_W-1:0] x);
    return (32'(x) > MAX_LEVEL) ? LW'(MAX_LEVEL) : LW'(x);
  endfunction

  // register writes
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      step_interval <= RST_STEP_INTERVAL;
      step_size     <= RST_STEP_SIZE;
      period        <= RST_PERIOD;
    end else if (cfg.valid) begin
      unique case (cfg.index)
        REG_STEP_INTERVAL: step_interval <= INTERVAL_W'(cfg.data);
        REG_STEP_SIZE:     step_size     <= STEP_W'(cfg.data);
        REG_PERIOD:        period        <= cfg.data;
        default: ;
      endcase
    end
  end

  // input register
  assign cmd.ready = !s0_valid || ld[0];

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      s0_valid <= 1'b1;
    end else if (ld[0]) begin
      s0_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      s0_op  <= cmd.operation;
      s0_now <= cmd.now_ms;
      s0_wl  <= cmd.warm_level_in;
      s0_cl  <= cmd.cool_level_in;
    end
  end

  // ramp step
  dcrpd_ramp #(.LW(LW)) u_ramp_w (
    .cur   (warm_level),
    .tgt   (warm_target),
    .step  (step_size),
    .nxt   (ramp_w),
    .moved (moved_w)
  );

  dcrpd_ramp #(.LW(LW)) u_ramp_c (
    .cur   (cool_level),
    .tgt   (cool_target),
    .step  (step_size),
    .nxt   (ramp_c),
    .moved (moved_c)
  );

  assign elapsed  = s0_now - last_step_time;
  assign step_due = (elapsed >= TIME_W'(step_interval));

  always_comb begin
    warm_target_next    = warm_target;
    cool_target_next    = cool_target;
    warm_level_next     = warm_level;
    cool_level_next     = cool_level;
    last_step_time_next = last_step_time;
    recompute           = 1'b0;
    zero                = 1'b0;
    unique case (s0_op)
      OP_POLL: begin
        if (step_due) begin
          last_step_time_next = s0_now;
          warm_level_next     = ramp_w;
          cool_level_next     = ramp_c;
          recompute           = moved_w || moved_c;
        end
      end
      OP_SET_WARM: warm_target_next = clamp_level(s0_wl);
      OP_SET_COOL: cool_target_next = clamp_level(s0_cl);
      OP_SET_BOTH: begin
        warm_target_next = clamp_level(s0_wl);
        cool_target_next = clamp_level(s0_cl);
      end
      OP_OFF: begin
        warm_target_next = '0;
        cool_target_next = '0;
        warm_level_next  = '0;
        cool_level_next  = '0;
        zero             = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      warm_target    <= '0;
      cool_target    <= '0;
      warm_level     <= '0;
      cool_level     <= '0;
      last_step_time <= '0;
    end else if (ld[0]) begin
      warm_target    <= warm_target_next;
      cool_target    <= cool_target_next;
      warm_level     <= warm_level_next;
      cool_level     <= cool_level_next;
      last_step_time <= last_step_time_next;
    end
  end

  always_comb begin
    sb_new.level_w   = LEVEL_OUT_W'(warm_level_next);
    sb_new.level_c   = LEVEL_OUT_W'(cool_level_next);
    sb_new.target_w  = LEVEL_OUT_W'(warm_target_next);
    sb_new.target_c  = LEVEL_OUT_W'(cool_target_next);
    sb_new.updated   = recompute || zero;
    sb_new.recompute = recompute;
    sb_new.zero      = zero;
  end

  // stage k moves forward when the stage after it has room; bubbles collapse
  assign ld_out        = v[NS-1] && (!rsp.valid || rsp.ready);
  assign free[NS-1]    = !v[NS-1] || ld_out;
  assign ld[0]         = s0_valid && free[0];

  for (genvar k = 0; k < NS - 1; k++) begin : g_ctl
    assign ld[k+1] = v[k] && free[k+1];
    assign free[k] = !v[k] || ld[k+1];
  end

  assign leave  = {ld_out, ld[NS-1:1]};
  assign v_next = (v & ~leave) | ld;

  always_ff @(posedge clk) begin
    if (rst) begin
      v <= '0;
    end else begin
      v <= v_next;
    end
  end

  always_ff @(posedge clk) begin
    if (ld[0]) begin
      sb[0] <= sb_new;
    end
  end

  for (genvar k = 1; k < NS; k++) begin : g_sb
    always_ff @(posedge clk) begin
      if (ld[k]) begin
        sb[k] <= sb[k-1];
      end
    end
  end

  // while stage 0 holds an item the level registers hold exactly its levels
  dcrpd_scale #(.MAX_LEVEL(MAX_LEVEL)) u_scale_w (
    .clk     (clk),
    .en      (ld[NS-1:1]),
    .period  (period),
    .level   (warm_level),
    .compare (cmp_w)
  );

  dcrpd_scale #(.MAX_LEVEL(MAX_LEVEL)) u_scale_c (
    .clk     (clk),
    .en      (ld[NS-1:1]),
    .period  (period),
    .level   (cool_level),
    .compare (cmp_c)
  );

  // output register, its compares double as the compare state
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (ld_out) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.warm_compare    <= '0;
      rsp.cool_compare    <= '0;
      rsp.warm_level_now  <= '0;
      rsp.cool_level_now  <= '0;
      rsp.warm_target_now <= '0;
      rsp.cool_target_now <= '0;
      rsp.compare_updated <= 1'b0;
    end else if (ld_out) begin
      if (sb[NS-1].recompute) begin
        rsp.warm_compare <= cmp_w;
        rsp.cool_compare <= cmp_c;
      end else if (sb[NS-1].zero) begin
        rsp.warm_compare <= '0;
        rsp.cool_compare <= '0;
      end
      rsp.warm_level_now  <= sb[NS-1].level_w;
      rsp.cool_level_now  <= sb[NS-1].level_c;
      rsp.warm_target_now <= sb[NS-1].target_w;
      rsp.cool_target_now <= sb[NS-1].target_c;
      rsp.compare_updated <= sb[NS-1].updated;
    end
  end

endmodule

FILE: rtl/core/dcrpd_ramp.sv
// ----------------------------------------------------------------------------
// dcrpd_ramp
// One slew step of a channel: moves the level toward its target by the step
// size without overshoot and flags whether the channel was off target.
// ----------------------------------------------------------------------------
module dcrpd_ramp #(
  parameter int unsigned LW = 10
) (
  input  logic [LW-1:0]                cur,
  input  logic [LW-1:0]                tgt,
  input  logic [dcrpd_pkg::STEP_W-1:0] step,
  output logic [LW-1:0]                nxt,
  output logic                         moved
);
  import dcrpd_pkg::*;

  localparam int unsigned SW = ((LW > STEP_W) ? LW : STEP_W) + 1;

  logic [SW-1:0] sum;
  logic [LW-1:0] diff;

  assign sum  = SW'(cur) + SW'(step);
  assign diff = cur - tgt;

  always_comb begin
    nxt   = cur;
    moved = 1'b0;
    if (cur != tgt) begin
      moved = 1'b1;
      if (cur < tgt) begin
        nxt = (sum > SW'(tgt)) ? tgt : LW'(sum);
      end else begin
        // cur is above step here whenever the subtraction is taken
        nxt = (SW'(diff) <= SW'(step)) ? tgt : LW'(SW'(cur) - SW'(step));
      end
    end
  end

endmodule

FILE: rtl/core/dcrpd_scale.sv
// ----------------------------------------------------------------------------
// dcrpd_scale
// Pipelined level to compare conversion: round(period * level / MAX_LEVEL),
// saturated to the compare width. One product stage, then a multiply by the
// rounded-up reciprocal of the constant.
// ----------------------------------------------------------------------------
module dcrpd_scale #(
  parameter int unsigned MAX_LEVEL = 1000
) (
  input  logic                                 clk,
  input  logic [dcrpd_pkg::SCALE_STAGES-1:0]   en,
  input  logic [dcrpd_pkg::PERIOD_W-1:0]       period,
  input  logic [$clog2(MAX_LEVEL+1)-1:0]       level,
  output logic [dcrpd_pkg::CMP_W-1:0]          compare
);
  import dcrpd_pkg::*;

  localparam int unsigned LW = $clog2(MAX_LEVEL + 1);
  localparam int unsigned PW = PERIOD_W + LW;
  localparam logic [PW-1:0] HALF    = PW'(MAX_LEVEL / 2);
  localparam logic [PW-1:0] SAT_LIM = PW'(MAX_LEVEL) << CMP_W;

  // below the saturation limit the rounded product fits in QW bits
  localparam int unsigned CL = $clog2(MAX_LEVEL);
  localparam int unsigned QW = CMP_W + CL;
  localparam int unsigned RS = QW + CL;
  localparam int unsigned MW = QW + 1;
  localparam int unsigned XW = QW + MW;
  localparam logic [63:0] RECIP =
    ((64'd1 << RS) + 64'(MAX_LEVEL) - 64'd1) / 64'(MAX_LEVEL);
  localparam logic [MW-1:0] RECIP_M = RECIP[MW-1:0];

  logic [PW-1:0]    prod;
  logic [XW-1:0]    recip_prod;
  logic [CMP_W-1:0] quot;
  logic             sat;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      prod <= PW'(period) * PW'(level) + HALF;
    end
  end

  // floor(prod / MAX_LEVEL), exact over the unsaturated range
  assign recip_prod = XW'(prod[QW-1:0]) * XW'(RECIP_M);

  always_ff @(posedge clk) begin
    if (en[1]) begin
      sat  <= (prod >= SAT_LIM);
      quot <= recip_prod[RS +: CMP_W];
    end
  end

  assign compare = sat ? '1 : quot;

endmodule

FILE: rtl/core/dcrpd_checker.sv
// ----------------------------------------------------------------------------
// dcrpd_checker
// Port-level checks on the dimmer: no result without a pending command,
// untouched compares on results that did not rewrite them, stalled results
// hold.
// ----------------------------------------------------------------------------
module dcrpd_checker (
  input logic                               clk,
  input logic                               rst,
  input logic                               cmd_valid,
  input logic                               cmd_ready,
  input logic                               rsp_valid,
  input logic                               rsp_ready,
  input logic [dcrpd_pkg::CMP_W-1:0]        warm_compare,
  input logic [dcrpd_pkg::CMP_W-1:0]        cool_compare,
  input logic                               compare_updated
);
  import dcrpd_pkg::*;

  logic [5:0]       pending;
  logic [CMP_W-1:0] last_w, last_c;
  logic             cmd_acc, rsp_acc;

  assign cmd_acc = cmd_valid && cmd_ready;
  assign rsp_acc = rsp_valid && rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      pending <= '0;
      last_w  <= '0;
      last_c  <= '0;
    end else begin
      pending <= pending + 6'(cmd_acc) - 6'(rsp_acc);
      if (rsp_acc) begin
        last_w <= warm_compare;
        last_c <= cool_compare;
      end
    end
  end

  a_no_orphan_result: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> pending != 6'd0)
    else $error("result shown with no command outstanding");

  a_compare_held: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !compare_updated |-> warm_compare == last_w && cool_compare == last_c)
    else $error("compares changed on a result that did not rewrite them");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(warm_compare) &&
      $stable(cool_compare) && $stable(compare_updated))
    else $error("stalled result dropped or changed");

endmodule

bind dual_channel_ramped_pwm_dimmer dcrpd_checker u_dcrpd_checker (
  .clk             (clk),
  .rst             (rst),
  .cmd_valid       (cmd.valid),
  .cmd_ready       (cmd.ready),
  .rsp_valid       (rsp.valid),
  .rsp_ready       (rsp.ready),
  .warm_compare    (rsp.warm_compare),
  .cool_compare    (rsp.cool_compare),
  .compare_updated (rsp.compare_updated)
);
